>>> hw/rtl/npci_pkg.sv
// Shared types and constants for the nearest palette color index core.
package npci_pkg;

  localparam int ColorW   = 8;
  localparam int DistW    = 18;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int UsedW    = 9;
  localparam int IndexW   = 8;

  typedef logic [DistW-1:0] dist_t;

  // running minimum start value, above any reachable distance
  localparam dist_t DistStart = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUsedEntries = 2'd0,
    CfgLockedValid = 2'd1,
    CfgLockedIndex = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } color_t;

  // scan token: tok marks a read in flight, qual marks it as a candidate
  typedef struct packed {
    logic tok;
    logic qual;
  } scan_tok_t;

endpackage

>>> hw/rtl/npci_palette_mem.sv
// Palette storage: one write port, one read port with registered read data.
module npci_palette_mem
  import npci_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  color_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output color_t        rdata_o
);

  color_t palette_q [2**AW];
  color_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      palette_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= palette_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/npci_dist.sv
// Distance pipeline: squared differences, then sum and running minimum.
module npci_dist
  import npci_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  color_t        query_i,
  input  color_t        entry_i,
  input  scan_tok_t     tok_i,
  input  logic [AW-1:0] idx_i,
  output logic          busy_o,
  output logic [AW-1:0] best_idx_o
);

  logic [ColorW-1:0]   dr, dg, db;
  logic [2*ColorW-1:0] sqr_d, sqg_d, sqb_d;
  logic [2*ColorW-1:0] sqr_q, sqg_q, sqb_q;
  scan_tok_t           tok2_q;
  logic [AW-1:0]       idx2_q;
  dist_t               sum;
  dist_t               best_dist_q;
  logic [AW-1:0]       best_idx_q;

  always_comb begin
    dr = (entry_i.red   >= query_i.red)   ? entry_i.red   - query_i.red
                                          : query_i.red   - entry_i.red;
    dg = (entry_i.green >= query_i.green) ? entry_i.green - query_i.green
                                          : query_i.green - entry_i.green;
    db = (entry_i.blue  >= query_i.blue)  ? entry_i.blue  - query_i.blue
                                          : query_i.blue  - entry_i.blue;
    sqr_d = dr * dr;
    sqg_d = dg * dg;
    sqb_d = db * db;
  end

  always_ff @(posedge clk_i) begin
    sqr_q  <= sqr_d;
    sqg_q  <= sqg_d;
    sqb_q  <= sqb_d;
    idx2_q <= idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
    end else begin
      tok2_q <= tok_i;
    end
  end

  assign sum = DistW'(sqr_q) + DistW'(sqg_q) + DistW'(sqb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DistStart;
      best_idx_q  <= '0;
    end else if (clear_i) begin
      best_dist_q <= DistStart;
      best_idx_q  <= '0;
    end else if (tok2_q.tok && tok2_q.qual && (sum < best_dist_q)) begin
      best_dist_q <= sum;
      best_idx_q  <= idx2_q;
    end
  end

  assign busy_o     = tok2_q.tok;
  assign best_idx_o = best_idx_q;

endmodule

>>> hw/rtl/nearest_palette_color_index_core.sv
// Top level: configuration, palette load and nearest color scan sequencer.
// A palette write (func 0) gives no result. A query (func 1) scans
// min(used_entries, PALETTE_DEPTH) entries, one per cycle through the single
// palette read port, and holds busy until the last read has left the distance
// pipeline.
// best_index_o is valid in the one cycle done_o is high, right after busy drops.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Configuration writes are taken at any time but must only be issued while idle.
module nearest_palette_color_index_core
  import npci_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [IndexW-1:0]   entry_index_i,
  input  logic [ColorW-1:0]   red_i,
  input  logic [ColorW-1:0]   green_i,
  input  logic [ColorW-1:0]   blue_i,
  output logic                done_o,
  output logic [IndexW-1:0]   best_index_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int XW = (AW > IndexW) ? AW : IndexW;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e          state_q;
  logic            done_q;
  logic [CW-1:0]   issue_cnt_q;
  logic [CW-1:0]   count_q;
  color_t          query_q;
  scan_tok_t       tok1_q;
  logic [AW-1:0]   idx1_q;

  logic [UsedW-1:0]  used_entries_q;
  logic              locked_valid_q;
  logic [IndexW-1:0] locked_index_q;

  logic            accept;
  logic            wr_en;
  logic            query_go;
  logic            issuing;
  logic            locked_hit;
  logic            finish;
  logic [CW-1:0]   count_d;
  logic [XW-1:0]   wr_idx_ext;
  logic [XW-1:0]   best_ext;
  color_t          in_color;
  color_t          entry_color;
  logic            pipe_busy;
  logic [AW-1:0]   best_idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_entries_q <= '0;
      locked_valid_q <= 1'b0;
      locked_index_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgUsedEntries: used_entries_q <= cfg_data_i;
        CfgLockedValid: locked_valid_q <= cfg_data_i[0];
        CfgLockedIndex: locked_index_q <= cfg_data_i[IndexW-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = start && !busy;
  assign in_color   = '{red: red_i, green: green_i, blue: blue_i};
  assign wr_idx_ext = XW'(entry_index_i);
  assign wr_en      = accept && (func_i == FuncWrite) &&
                      (32'(entry_index_i) < 32'(PALETTE_DEPTH));
  assign query_go   = accept && (func_i == FuncQuery);
  assign count_d    = (32'(used_entries_q) > 32'(PALETTE_DEPTH)) ?
                      CW'(PALETTE_DEPTH) : CW'(used_entries_q);
  assign issuing    = (state_q == StScan) && (issue_cnt_q != count_q);
  assign locked_hit = locked_valid_q && (32'(issue_cnt_q) == 32'(locked_index_q));
  assign finish     = (state_q == StScan) && (issue_cnt_q == count_q) &&
                      !tok1_q.tok && !pipe_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      issue_cnt_q <= '0;
      count_q     <= '0;
      tok1_q      <= '0;
    end else begin
      done_q <= 1'b0;
      tok1_q <= '{tok: issuing, qual: !locked_hit};
      unique case (state_q)
        StIdle: begin
          if (query_go) begin
            state_q     <= StScan;
            issue_cnt_q <= '0;
            count_q     <= count_d;
          end
        end
        StScan: begin
          if (issuing) begin
            issue_cnt_q <= issue_cnt_q + CW'(1);
          end
          if (finish) begin
            state_q <= StIdle;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      query_q <= in_color;
    end
    idx1_q <= issue_cnt_q[AW-1:0];
  end

  npci_palette_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx_ext[AW-1:0]),
    .wdata_i (in_color),
    .re_i    (issuing),
    .raddr_i (issue_cnt_q[AW-1:0]),
    .rdata_o (entry_color)
  );

  npci_dist #(
    .AW (AW)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (query_go),
    .query_i    (query_q),
    .entry_i    (entry_color),
    .tok_i      (tok1_q),
    .idx_i      (idx1_q),
    .busy_o     (pipe_busy),
    .best_idx_o (best_idx)
  );

  assign best_ext     = XW'(best_idx);
  assign best_index_o = best_ext[IndexW-1:0];
  assign busy         = (state_q == StScan);
  assign done_o       = done_q;

endmodule

>>> hw/rtl/npci_checker.sv
// Port-level checker for the nearest palette color index core, with its bind.
module npci_checker
  import npci_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                func_i,
  input logic                done_o
);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a preceding busy query");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncWrite) |=> !done_o)
    else $error("palette write produced a result beat");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncQuery) |=> busy)
    else $error("accepted query did not raise busy");

  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("query finished without a result beat");

endmodule

bind nearest_palette_color_index_core npci_checker u_npci_checker (.*);
